// ----- hdl/ace_pkg.sv -----
// Shared types and operation codes for the accumulator execute unit.
`timescale 1ns / 1ps

package ace_pkg;

   localparam int NumRegs   = 8;
   localparam int MemDepth  = 256;
   localparam int RegIdxW   = $clog2(NumRegs);
   localparam int MemAddrW  = $clog2(MemDepth);
   localparam int CmdW      = 5;
   localparam int ImmW      = 8;
   localparam int CntW      = 8;
   localparam int AccOutW   = 16;

   localparam logic [RegIdxW-1:0] STACK_REG = RegIdxW'(7);

   localparam logic [CmdW-1:0] CMD_TICK     = 5'd0;
   localparam logic [CmdW-1:0] CMD_ADD      = 5'd1;
   localparam logic [CmdW-1:0] CMD_SUB      = 5'd2;
   localparam logic [CmdW-1:0] CMD_SSP      = 5'd3;
   localparam logic [CmdW-1:0] CMD_INC      = 5'd4;
   localparam logic [CmdW-1:0] CMD_DEC      = 5'd5;
   localparam logic [CmdW-1:0] CMD_NEG      = 5'd6;
   localparam logic [CmdW-1:0] CMD_NOT      = 5'd7;
   localparam logic [CmdW-1:0] CMD_AND      = 5'd8;
   localparam logic [CmdW-1:0] CMD_OR       = 5'd9;
   localparam logic [CmdW-1:0] CMD_LDA_IMM  = 5'd10;
   localparam logic [CmdW-1:0] CMD_ST_IMM   = 5'd11;
   localparam logic [CmdW-1:0] CMD_LD_REG   = 5'd12;
   localparam logic [CmdW-1:0] CMD_ST_REG   = 5'd13;
   localparam logic [CmdW-1:0] CMD_LDA_REG  = 5'd14;
   localparam logic [CmdW-1:0] CMD_MOV_ACC  = 5'd15;
   localparam logic [CmdW-1:0] CMD_LDA_ACC  = 5'd16;
   localparam logic [CmdW-1:0] CMD_ST_ACC   = 5'd17;
   localparam logic [CmdW-1:0] CMD_ST_CNT   = 5'd18;
   localparam logic [CmdW-1:0] CMD_JMP_ADDR = 5'd19;
   localparam logic [CmdW-1:0] CMD_JMP      = 5'd20;
   localparam logic [CmdW-1:0] CMD_JZ       = 5'd21;
   localparam logic [CmdW-1:0] CMD_JN       = 5'd22;
   localparam logic [CmdW-1:0] CMD_JOV      = 5'd23;

   typedef struct packed {
      logic [CmdW-1:0]    command;
      logic [RegIdxW-1:0] reg_x;
      logic [RegIdxW-1:0] reg_y;
      logic [ImmW-1:0]    immediate;
   } req_type;

   typedef struct packed {
      logic [CntW-1:0]           counter_value;
      logic signed [AccOutW-1:0] accumulator;
      logic [MemAddrW-1:0]       address_value;
   } rsp_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [MemAddrW-1:0] addr;
   } mem_ctl_type;

endpackage

// ----- hdl/ace_dmem.sv -----
// Data memory with per-entry valid bits so that unwritten entries read as zero.
`timescale 1ns / 1ps

module ace_dmem
   import ace_pkg::*;
#(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mem_ctl_type           mem_ctl,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [MemDepth];
   logic [MemDepth-1:0]   valid_ff;
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic                  rvalid_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[mem_ctl.addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= mem_ff[mem_ctl.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (mem_ctl.wr_en) begin
            valid_ff[mem_ctl.addr] <= 1'b1;
         end
         if (mem_ctl.rd_en) begin
            rvalid_ff <= valid_ff[mem_ctl.addr];
         end
      end
   end

   // never-written entries read as zero, as their valid bits are cleared by reset
   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

// ----- hdl/ace_alu.sv -----
// Operation decode and datapath: next architectural state for one word.
`timescale 1ns / 1ps

module ace_alu
   import ace_pkg::*;
#(
   parameter int DATA_WIDTH = 16
) (
   input  req_type               op,
   input  logic [DATA_WIDTH-1:0] rx,
   input  logic [DATA_WIDTH-1:0] ry,
   input  logic [DATA_WIDTH-1:0] rsp_reg,
   input  logic [DATA_WIDTH-1:0] acc,
   input  logic [MemAddrW-1:0]   addr,
   input  logic [CntW-1:0]       cnt,
   output logic [DATA_WIDTH-1:0] acc_next,
   output logic [MemAddrW-1:0]   addr_next,
   output logic [CntW-1:0]       cnt_next,
   output logic [CntW-1:0]       cnt_shown,
   output logic                  rf_we,
   output logic                  ld_req,
   output mem_ctl_type           mem_ctl,
   output logic [DATA_WIDTH-1:0] mem_wdata
);

   logic [CntW-1:0] target;
   logic            acc_zero;
   logic            acc_neg;
   logic            acc_over;

   assign target   = CntW'(op.immediate) + CntW'(1);
   assign acc_zero = (acc == '0);
   assign acc_neg  = acc[DATA_WIDTH-1];
   // signed compare against 256: positive with any bit above bit 7 set
   assign acc_over = !acc_neg && (|acc[DATA_WIDTH-2:8]);

   always_comb begin
      acc_next      = acc;
      addr_next     = addr;
      cnt_next      = cnt;
      cnt_shown     = cnt;
      rf_we         = 1'b0;
      ld_req        = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.addr  = addr;
      mem_wdata     = acc;
      case (op.command)
         CMD_TICK:     cnt_next = cnt + CntW'(1);
         CMD_ADD:      acc_next = rx + ry;
         CMD_SUB:      acc_next = rx - ry;
         CMD_SSP:      acc_next = rsp_reg - DATA_WIDTH'(op.immediate);
         CMD_INC:      acc_next = rx + DATA_WIDTH'(1);
         CMD_DEC:      acc_next = rx - DATA_WIDTH'(1);
         CMD_NEG:      acc_next = '0 - rx;
         CMD_NOT:      acc_next = ~rx;
         CMD_AND:      acc_next = rx & ry;
         CMD_OR:       acc_next = rx | ry;
         CMD_LDA_IMM:  addr_next = op.immediate;
         CMD_ST_IMM: begin
            mem_ctl.wr_en = 1'b1;
            mem_wdata     = DATA_WIDTH'(op.immediate);
         end
         CMD_LD_REG: begin
            mem_ctl.rd_en = 1'b1;
            ld_req        = 1'b1;
         end
         CMD_ST_REG: begin
            mem_ctl.wr_en = 1'b1;
            mem_wdata     = rx;
         end
         CMD_LDA_REG:  addr_next = rx[MemAddrW-1:0];
         CMD_MOV_ACC:  rf_we = 1'b1;
         CMD_LDA_ACC:  addr_next = acc[MemAddrW-1:0];
         CMD_ST_ACC:   mem_ctl.wr_en = 1'b1;
         CMD_ST_CNT: begin
            mem_ctl.wr_en = 1'b1;
            mem_wdata     = DATA_WIDTH'(cnt);
         end
         CMD_JMP_ADDR: cnt_next = addr + CntW'(1);
         CMD_JMP:      cnt_next = target;
         CMD_JZ:       if (acc_zero) cnt_next = target;
         CMD_JN:       if (acc_neg) cnt_next = target;
         CMD_JOV:      if (acc_over) cnt_next = target;
         default: ;
      endcase
      // tick reports the counter before its increment
      if (op.command != CMD_TICK) begin
         cnt_shown = cnt_next;
      end
   end

endmodule

// ----- hdl/accumulator_cpu_execute.sv -----
// Throughput: one word per cycle while the result side does not stall; an input register
// and a result register part the sides, and each result word is registered.
// Loads from data memory write the register file in the cycle after the word executes, with forwarding.
// Reset (synchronous, active high) clears registers, accumulator, address and counter,
// and the memory valid bits at once, so memory reads as zero with no clearing pass.
`timescale 1ns / 1ps

module accumulator_cpu_execute
   import ace_pkg::*;
#(
   parameter int DATA_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ExtW = (DATA_WIDTH > AccOutW) ? DATA_WIDTH : AccOutW;

   logic                  in_valid_ff, in_valid_in;
   req_type               in_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [MemAddrW-1:0]   addr_ff, addr_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rf_ff [NumRegs];
   logic [DATA_WIDTH-1:0] rf_in [NumRegs];
   logic                  ld_pend_ff, ld_pend_in;
   logic [RegIdxW-1:0]    ld_idx_ff;

   logic                  advance;
   logic [DATA_WIDTH-1:0] rf_fwd [NumRegs];
   logic [DATA_WIDTH-1:0] ld_data;
   logic [DATA_WIDTH-1:0] acc_next;
   logic [MemAddrW-1:0]   addr_next;
   logic [CntW-1:0]       cnt_next;
   logic [CntW-1:0]       cnt_shown;
   logic                  rf_we;
   logic                  ld_req;
   mem_ctl_type           alu_mem_ctl;
   mem_ctl_type           mem_ctl;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [ExtW-1:0]       acc_ext;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // forward a load that lands this cycle
   always_comb begin
      for (int i = 0; i < NumRegs; i++) begin
         rf_fwd[i] = (ld_pend_ff && ld_idx_ff == RegIdxW'(i)) ? ld_data : rf_ff[i];
      end
   end

   ace_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .op        (in_data_ff),
      .rx        (rf_fwd[in_data_ff.reg_x]),
      .ry        (rf_fwd[in_data_ff.reg_y]),
      .rsp_reg   (rf_fwd[STACK_REG]),
      .acc       (acc_ff),
      .addr      (addr_ff),
      .cnt       (cnt_ff),
      .acc_next  (acc_next),
      .addr_next (addr_next),
      .cnt_next  (cnt_next),
      .cnt_shown (cnt_shown),
      .rf_we     (rf_we),
      .ld_req    (ld_req),
      .mem_ctl   (alu_mem_ctl),
      .mem_wdata (mem_wdata)
   );

   always_comb begin
      mem_ctl       = alu_mem_ctl;
      mem_ctl.rd_en = alu_mem_ctl.rd_en && advance;
      mem_ctl.wr_en = alu_mem_ctl.wr_en && advance;
   end

   ace_dmem #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .mem_ctl (mem_ctl),
      .wr_data (mem_wdata),
      .rd_data (ld_data)
   );

   assign acc_ext = ExtW'(acc_next);

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      acc_in       = acc_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      ld_pend_in   = advance && ld_req;
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         acc_in       = acc_next;
         addr_in      = addr_next;
         cnt_in       = cnt_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
      // an older load lands first; a move in the current word overrides it
      for (int i = 0; i < NumRegs; i++) begin
         rf_in[i] = rf_fwd[i];
         if (advance && rf_we && in_data_ff.reg_x == RegIdxW'(i)) begin
            rf_in[i] = acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         addr_ff      <= '0;
         cnt_ff       <= '0;
         ld_pend_ff   <= 1'b0;
         for (int i = 0; i < NumRegs; i++) begin
            rf_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         ld_pend_ff   <= ld_pend_in;
         for (int i = 0; i < NumRegs; i++) begin
            rf_ff[i] <= rf_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff.counter_value <= cnt_shown;
         rsp_data_ff.accumulator   <= acc_ext[AccOutW-1:0];
         rsp_data_ff.address_value <= addr_next;
         ld_idx_ff                 <= in_data_ff.reg_x;
      end
   end

`ifndef SYNTH
   a_ld_from_advance : assert property (@(posedge clock) disable iff (reset)
      ld_pend_ff |-> $past(advance))
      else $error("load writeback without an executed word");

   a_advance_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("executed word produced no result");

   a_stall_only_on_rsp : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !req_ready) |-> (rsp_valid_ff && !rsp_ready))
      else $error("input held without a result stall");

   a_tick_steps_counter : assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.command == CMD_TICK) |=> cnt_ff == $past(cnt_ff) + CntW'(1))
      else $error("tick did not advance the counter");
`endif

endmodule
